>>> sv/ffpa_pkg.sv
// Shared types and constants for the first-fit partition allocator.
`default_nettype none
package ffpa_pkg;
  localparam int QUEUE_DEPTH = 8;
  localparam int NUM_SLOTS   = 8;
  localparam int QA_W = $clog2(QUEUE_DEPTH);
  localparam int QL_W = $clog2(QUEUE_DEPTH + 1);
  localparam int SL_W = $clog2(NUM_SLOTS + 1);
  localparam int JOB_W = 40;

  typedef enum logic [1:0] {
    OP_ENQ   = 2'd0,
    OP_ALLOC = 2'd1,
    OP_SIZE  = 2'd2,
    OP_NONE  = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    ST_QUEUED  = 3'd0,
    ST_FULL    = 3'd1,
    ST_ALLOC   = 3'd2,
    ST_EMPTY   = 3'd3,
    ST_NOFIT   = 3'd4,
    ST_SIZEWR  = 3'd5
  } status_t;

  typedef enum logic [0:0] {
    FS_IDLE = 1'b0,
    FS_POP  = 1'b1
  } fsm_t;
endpackage
`default_nettype wire

>>> sv/ffpa_ram.sv
// Generic single-port-write, registered-read RAM.
`default_nettype none
module ffpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

>>> sv/first_fit_partition_allocator_core.sv
// Top level: job queue in RAM, partition table in registers, APB config port.
// Usage: raise start with an opcode while busy is low. Enqueue, size write and
// unused opcodes give their result in the next cycle; allocate first moves to
// the pop state, where the head job, read from the queue RAM (registered read),
// feeds the first-fit search. The result appears for exactly one cycle with done high;
// the receiver cannot stall it. Aging and the search over the partitions in use run
// in parallel in the pop state. No clearing pass after reset.
`default_nettype none
module first_fit_partition_allocator_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  opcode,
  input  wire logic [7:0]  job_id,
  input  wire logic [15:0] job_size,
  input  wire logic [15:0] run_time,
  input  wire logic [2:0]  slot_select,
  input  wire logic [15:0] slot_size,
  output logic             done,
  output logic [2:0]       status,
  output logic [2:0]       granted_slot,
  output logic [7:0]       popped_job,
  output logic [7:0]       freed_mask,
  output logic [3:0]       queue_level,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic        paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  localparam int N = ffpa_pkg::NUM_SLOTS;

  logic [3:0] piu;
  ffpa_pkg::fsm_t state, state_next;
  logic [ffpa_pkg::QA_W-1:0] head, tail;
  logic [ffpa_pkg::QL_W-1:0] level;
  logic [15:0] cap [N];
  logic [N-1:0] sbusy;
  logic [7:0]  owner [N];
  logic [15:0] tleft [N];
  logic [ffpa_pkg::JOB_W-1:0] rdata;
  logic acc, enq_ok;
  logic [ffpa_pkg::SL_W-1:0] nuse;

  assign pready = 1'b1;
  assign prdata = {28'd0, piu};
  assign acc = start && !busy;
  assign busy = (state == ffpa_pkg::FS_POP);
  assign enq_ok = acc && opcode == ffpa_pkg::OP_ENQ
                  && level < ffpa_pkg::QL_W'(ffpa_pkg::QUEUE_DEPTH);
  assign nuse = (32'(piu) > N) ? ffpa_pkg::SL_W'(N) : ffpa_pkg::SL_W'(piu);

  ffpa_ram #(.WIDTH(ffpa_pkg::JOB_W), .DEPTH(ffpa_pkg::QUEUE_DEPTH)) u_q (
    .clk(clk), .we(enq_ok), .waddr(tail),
    .wdata({job_id, job_size, run_time}), .raddr(head), .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) piu <= 4'd8;
    else if (psel && penable && pwrite && !paddr) piu <= pwdata[3:0];
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ffpa_pkg::FS_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      ffpa_pkg::FS_IDLE: if (acc && opcode == ffpa_pkg::OP_ALLOC) state_next = ffpa_pkg::FS_POP;
      ffpa_pkg::FS_POP:  state_next = ffpa_pkg::FS_IDLE;
      default:           state_next = ffpa_pkg::FS_IDLE;
    endcase
  end

  // aging and first fit, evaluated in the pop cycle
  logic [N-1:0] in_use, freed, busy_aged, fit;
  logic [15:0] tl_aged [N];
  logic found;
  logic [$clog2(N)-1:0] pick;
  logic hav;
  logic [7:0]  j_id;
  logic [15:0] j_sz, j_tm;
  assign {j_id, j_sz, j_tm} = rdata;
  assign hav = level != '0;

  always_comb begin
    found = 1'b0;
    pick = '0;
    for (int i = 0; i < N; i++) begin
      in_use[i] = 32'(i) < 32'(nuse);
      freed[i] = in_use[i] && sbusy[i] && tleft[i] <= 16'd1;
      busy_aged[i] = sbusy[i] && !freed[i];
      tl_aged[i] = (in_use[i] && busy_aged[i]) ? tleft[i] - 16'd1 : tleft[i];
      fit[i] = in_use[i] && !busy_aged[i] && cap[i] >= j_sz;
    end
    for (int i = N - 1; i >= 0; i--) begin
      if (fit[i]) begin
        found = 1'b1;
        pick = ($clog2(N))'(i);
      end
    end
  end

  logic pop;
  assign pop = busy && hav;

  // partition table next state: aging first, then the grant on top
  logic [N-1:0] sbusy_next;
  logic [7:0]  owner_next [N];
  logic [15:0] tleft_next [N];

  always_comb begin
    for (int i = 0; i < N; i++) begin
      sbusy_next[i] = sbusy[i];
      owner_next[i] = owner[i];
      tleft_next[i] = tleft[i];
      if (busy) begin
        sbusy_next[i] = busy_aged[i];
        owner_next[i] = freed[i] ? 8'd0 : owner[i];
        tleft_next[i] = freed[i] ? 16'd0 : tl_aged[i];
      end
    end
    if (pop && found) begin
      sbusy_next[pick] = 1'b1;
      owner_next[pick] = j_id;
      tleft_next[pick] = j_tm;
    end
  end

  // queue pointers and the result of the current transfer
  logic [ffpa_pkg::QA_W-1:0] head_next, tail_next;
  logic [ffpa_pkg::QL_W-1:0] level_next;
  logic       done_next;
  logic [2:0] status_next, granted_next;
  logic [7:0] popped_next, freed_next;
  logic [3:0] qlvl_next;

  always_comb begin
    head_next = head;
    tail_next = tail;
    level_next = level;
    done_next = 1'b0;
    status_next = status;
    granted_next = granted_slot;
    popped_next = popped_job;
    freed_next = freed_mask;
    qlvl_next = queue_level;
    if (acc && opcode != ffpa_pkg::OP_ALLOC) begin
      done_next = 1'b1;
      granted_next = '0;
      popped_next = '0;
      freed_next = '0;
      case (opcode)
        ffpa_pkg::OP_ENQ: begin
          if (enq_ok) begin
            tail_next = (32'(tail) + 1 >= ffpa_pkg::QUEUE_DEPTH) ? '0 : tail + 1'b1;
            level_next = level + 1'b1;
            qlvl_next = 4'(level + 1'b1);
            status_next = ffpa_pkg::ST_QUEUED;
          end else begin
            qlvl_next = 4'(level);
            status_next = ffpa_pkg::ST_FULL;
          end
        end
        default: begin
          qlvl_next = 4'(level);
          status_next = ffpa_pkg::ST_SIZEWR;
        end
      endcase
    end else if (busy) begin
      done_next = 1'b1;
      freed_next = 8'(freed);
      granted_next = '0;
      popped_next = pop ? j_id : 8'd0;
      if (!hav) begin
        status_next = ffpa_pkg::ST_EMPTY;
        qlvl_next = 4'(level);
      end else begin
        head_next = (32'(head) + 1 >= ffpa_pkg::QUEUE_DEPTH) ? '0 : head + 1'b1;
        level_next = level - 1'b1;
        qlvl_next = 4'(level - 1'b1);
        status_next = found ? ffpa_pkg::ST_ALLOC : ffpa_pkg::ST_NOFIT;
        if (found) granted_next = 3'(pick);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0; tail <= '0; level <= '0; sbusy <= '0; done <= 1'b0;
      for (int i = 0; i < N; i++) begin
        cap[i] <= '0; owner[i] <= '0; tleft[i] <= '0;
      end
    end else begin
      head <= head_next;
      tail <= tail_next;
      level <= level_next;
      done <= done_next;
      status <= status_next;
      granted_slot <= granted_next;
      popped_job <= popped_next;
      freed_mask <= freed_next;
      queue_level <= qlvl_next;
      sbusy <= sbusy_next;
      for (int i = 0; i < N; i++) begin
        owner[i] <= owner_next[i];
        tleft[i] <= tleft_next[i];
      end
      if (acc && opcode == ffpa_pkg::OP_SIZE && 32'(slot_select) < N)
        cap[slot_select[$clog2(N)-1:0]] <= slot_size;
    end
  end

  a_lvl: assert property (@(posedge clk) disable iff (rst)
    level <= ffpa_pkg::QL_W'(ffpa_pkg::QUEUE_DEPTH)) else $error("level overflow");
  a_done: assert property (@(posedge clk) disable iff (rst)
    busy |=> done) else $error("pop without result");
  a_start: assert property (@(posedge clk) disable iff (rst)
    (acc && opcode != ffpa_pkg::OP_ALLOC) |=> done) else $error("missing result");
  a_busy1: assert property (@(posedge clk) disable iff (rst)
    busy |=> !busy) else $error("busy too long");
endmodule
`default_nettype wire

>>> bench/tb_first_fit_partition_allocator_core.sv
// Self-checking bench for the first-fit partition allocator core.
`default_nettype none
module tb_first_fit_partition_allocator_core;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [2:0] status;
    logic [2:0] granted_slot;
    logic [7:0] popped_job;
    logic [7:0] freed_mask;
    logic [3:0] queue_level;
  } alloc_result_t;

  typedef struct packed {
    logic [7:0]  id;
    logic [15:0] size;
    logic [15:0] run_time;
  } pending_job_t;

  // Shadow of the allocator: job ring, partition table, register, plus the
  // queue of results still owed by the block.
  class alloc_scoreboard;
    pending_job_t  jobs[ffpa_pkg::QUEUE_DEPTH];
    int            head, tail, level;
    logic [15:0]   capacity[ffpa_pkg::NUM_SLOTS];
    bit            occupied[ffpa_pkg::NUM_SLOTS];
    logic [7:0]    owner[ffpa_pkg::NUM_SLOTS];
    logic [15:0]   time_left[ffpa_pkg::NUM_SLOTS];
    logic [3:0]    slots_in_use;
    alloc_result_t owed[$];
    int            mismatches;

    function void clear();
      head = 0; tail = 0; level = 0;
      foreach (capacity[i]) begin
        capacity[i] = '0; occupied[i] = 0; owner[i] = '0; time_left[i] = '0;
      end
      slots_in_use = 4'd8;
      owed.delete();
      mismatches = 0;
    endfunction

    function void write_reg(logic [31:0] value);
      slots_in_use = value[3:0];
    endfunction

    function int pending();
      return owed.size();
    endfunction

    // Accepted transfer: advance the shadow state and queue the expected result.
    function void note_transfer(ffpa_pkg::opcode_t op, logic [7:0] id,
                                logic [15:0] jsize, logic [15:0] rtime,
                                logic [2:0] sel, logic [15:0] ssize);
      alloc_result_t r;
      pending_job_t  j;
      int            n;
      r = '0;
      r.status = ffpa_pkg::ST_SIZEWR;
      n = (slots_in_use > ffpa_pkg::NUM_SLOTS) ? ffpa_pkg::NUM_SLOTS : slots_in_use;
      case (op)
        ffpa_pkg::OP_ENQ: begin
          if (level >= ffpa_pkg::QUEUE_DEPTH) r.status = ffpa_pkg::ST_FULL;
          else begin
            jobs[tail] = '{id, jsize, rtime};
            tail = (tail + 1) % ffpa_pkg::QUEUE_DEPTH;
            level++;
            r.status = ffpa_pkg::ST_QUEUED;
          end
        end
        ffpa_pkg::OP_ALLOC: begin
          // aging comes before the search, so a slot freed here can be regranted
          for (int i = 0; i < n; i++) begin
            if (occupied[i]) begin
              if (time_left[i] <= 1) begin
                occupied[i] = 0; owner[i] = '0; time_left[i] = '0;
                r.freed_mask[i] = 1'b1;
              end else time_left[i] = time_left[i] - 1;
            end
          end
          if (level == 0) r.status = ffpa_pkg::ST_EMPTY;
          else begin
            j = jobs[head];
            head = (head + 1) % ffpa_pkg::QUEUE_DEPTH;
            level--;
            r.popped_job = j.id;
            r.status = ffpa_pkg::ST_NOFIT;
            for (int i = 0; i < n; i++) begin
              if (!occupied[i] && capacity[i] >= j.size) begin
                occupied[i] = 1; owner[i] = j.id; time_left[i] = j.run_time;
                r.granted_slot = i[2:0];
                r.status = ffpa_pkg::ST_ALLOC;
                break;
              end
            end
          end
        end
        ffpa_pkg::OP_SIZE: capacity[sel] = ssize;
        default: ;
      endcase
      r.queue_level = level[3:0];
      owed.push_back(r);
    endfunction

    function void check_result(alloc_result_t got);
      alloc_result_t want;
      if (owed.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
        return;
      end
      want = owed.pop_front();
      if (got.status !== want.status || got.granted_slot !== want.granted_slot ||
          got.popped_job !== want.popped_job || got.freed_mask !== want.freed_mask ||
          got.queue_level !== want.queue_level) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch at %0t: expected %p, got %p", $realtime, want, got);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [1:0]  opcode = '0;
  logic [7:0]  job_id = '0;
  logic [15:0] job_size = '0;
  logic [15:0] run_time = '0;
  logic [2:0]  slot_select = '0;
  logic [15:0] slot_size = '0;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0, paddr = 1'b0;
  logic [31:0] pwdata = '0;
  logic        busy, done, pready;
  logic [2:0]  status, granted_slot;
  logic [7:0]  popped_job, freed_mask;
  logic [3:0]  queue_level;
  logic [31:0] prdata;

  alloc_scoreboard sb = new();
  int sender_idle_pct;   // chance in percent of a gap before a transfer
  int burst_left;        // transfers still to go with no gap at all

  first_fit_partition_allocator_core i_dut (
    .clk, .rst, .start, .busy, .opcode, .job_id, .job_size, .run_time,
    .slot_select, .slot_size, .done, .status, .granted_slot, .popped_job,
    .freed_mask, .queue_level, .psel, .penable, .pwrite, .paddr, .pwdata,
    .prdata, .pready
  );

  always #4 clk = ~clk;

  // Monitor: results first, since a result always belongs to an older transfer.
  always @(posedge clk) begin
    if (!rst) begin
      if (done) sb.check_result({status, granted_slot, popped_job, freed_mask, queue_level});
      if (start && !busy)
        sb.note_transfer(ffpa_pkg::opcode_t'(opcode), job_id, job_size, run_time,
                         slot_select, slot_size);
    end
  end

  // One command transfer; start stays high into the next one when no gap follows.
  task automatic issue(ffpa_pkg::opcode_t op, logic [7:0] id, logic [15:0] jsize,
                       logic [15:0] rtime, logic [2:0] sel, logic [15:0] ssize);
    if (burst_left > 0) burst_left--;
    else if ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end else if ($urandom_range(29) == 0) burst_left = $urandom_range(5, 20);
    start <= 1'b1;
    opcode <= op; job_id <= id; job_size <= jsize; run_time <= rtime;
    slot_select <= sel; slot_size <= ssize;
    do @(posedge clk); while (busy);
  endtask

  // Drain all owed results, then let the allocate pipeline settle.
  task automatic go_quiet();
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Register write; shadow copy updated on the access edge.
  task automatic write_slots_in_use(logic [3:0] value);
    logic [31:0] word;
    word = {$urandom_range(1) ? 28'($urandom) : 28'd0, value};
    psel <= 1'b1; pwrite <= 1'b1; paddr <= 1'b0; pwdata <= word; penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    sb.write_reg(word);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic random_item();
    int pick;
    logic [15:0] jsize, rtime;
    pick = $urandom_range(99);
    // sizes mostly near typical capacities so that fits and misses both happen
    jsize = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 300));
    rtime = ($urandom_range(19) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6));
    if (pick < 42)
      issue(ffpa_pkg::OP_ENQ, 8'($urandom), jsize, rtime, 3'($urandom), 16'($urandom));
    else if (pick < 84)
      issue(ffpa_pkg::OP_ALLOC, 8'($urandom), 16'($urandom), 16'($urandom),
            3'($urandom), 16'($urandom));
    else if (pick < 96)
      issue(ffpa_pkg::OP_SIZE, 8'($urandom), 16'($urandom), 16'($urandom),
            3'($urandom),
            ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 320)));
    else
      issue(ffpa_pkg::OP_NONE, 8'($urandom), 16'($urandom), 16'($urandom),
            3'($urandom), 16'($urandom));
  endtask

  initial begin
    #5ms;
    $display("[first_fit_partition_allocator_core] ERROR");
    $finish;
  end

  initial begin
    logic [3:0] reg_values[6] = '{4'd8, 4'd0, 4'd15, 4'd1, 4'd3, 4'd9};
    sb.clear();
    sender_idle_pct = 28;
    burst_left = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty allocate, size extremes, full queue, zero run time, unused op.
    issue(ffpa_pkg::OP_ALLOC, 8'hFF, 16'hFFFF, 16'hFFFF, 3'd7, 16'hFFFF);
    issue(ffpa_pkg::OP_SIZE, 8'h00, 16'h0000, 16'h0000, 3'd0, 16'h0000);
    issue(ffpa_pkg::OP_SIZE, 8'h00, 16'h0000, 16'h0000, 3'd7, 16'hFFFF);
    issue(ffpa_pkg::OP_SIZE, 8'h00, 16'h0000, 16'h0000, 3'd3, 16'd100);
    for (int i = 0; i < 9; i++)
      issue(ffpa_pkg::OP_ENQ, 8'(i == 0 ? 8'hFF : i), i == 1 ? 16'hFFFF : 16'(i * 20),
            i == 2 ? 16'hFFFF : 16'(i % 3), 3'd0, 16'd0);
    issue(ffpa_pkg::OP_NONE, 8'hAA, 16'h5555, 16'hAAAA, 3'd5, 16'h5555);
    for (int i = 0; i < 9; i++)
      issue(ffpa_pkg::OP_ALLOC, 8'd0, 16'd0, 16'd0, 3'd0, 16'd0);
    go_quiet();
    write_slots_in_use(4'd0);
    issue(ffpa_pkg::OP_ENQ, 8'h01, 16'd0, 16'd0, 3'd0, 16'd0);
    issue(ffpa_pkg::OP_ALLOC, 8'd0, 16'd0, 16'd0, 3'd0, 16'd0);
    go_quiet();
    write_slots_in_use(4'd15);

    // Random: three idle regimes, each cycling through register settings.
    for (int phase = 0; phase < 3; phase++) begin
      sender_idle_pct = (phase == 0) ? 28 : (phase == 1) ? 67 : 0;
      for (int k = 0; k < 6; k++) begin
        go_quiet();
        write_slots_in_use(reg_values[(k + phase) % 6]);
        for (int i = 0; i < 6; i++)
          issue(ffpa_pkg::OP_SIZE, 8'($urandom), 16'($urandom), 16'($urandom), 3'(i),
                16'($urandom_range(0, 320)));
        for (int i = 0; i < 80; i++) random_item();
      end
    end

    go_quiet();
    repeat (10) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("[first_fit_partition_allocator_core] OK");
    else
      $display("[first_fit_partition_allocator_core] ERROR");
    $finish;
  end
endmodule
`default_nettype wire
